[hdl/embedding_vector_distance_top_assert.svh]
// ---------------------------------------------------------------------------
// embedding vector distance assertion macros
// concurrent checks that compile away when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef EMBEDDING_VECTOR_DISTANCE_TOP_ASSERT_SVH
`define EMBEDDING_VECTOR_DISTANCE_TOP_ASSERT_SVH
`ifndef SYNTH
// property holds at every clock edge outside reset
`define EVD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// expression never true outside reset
`define EVD_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define EVD_ASSERT(lbl, prop, msg)
`define EVD_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[hdl/evd_pkg.sv]
// ---------------------------------------------------------------------------
// evd_pkg
// shared widths, types and states of the embedding vector distance block
// ---------------------------------------------------------------------------
`default_nettype none
package evd_pkg;
	localparam int MAX_LENGTH = 128;
	localparam int ELEM_BITS  = 16;
	localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
	localparam int PROD_X_W   = 2 * ELEM_BITS + 2;
	localparam int DOT_W      = 40;
	localparam int NORM_W     = 39;
	localparam int DIFF_W     = 40;
	localparam int COS_W      = 32;
	localparam int ND_W       = 33;
	localparam int PP_W       = 2 * NORM_W;
	localparam int MAG_W      = DOT_W;
	localparam int MSQ_W      = 2 * MAG_W;
	localparam int FRAC_SHIFT = 62;
	localparam int DVD_W      = MSQ_W + FRAC_SHIFT;
	localparam int QUO_W      = 64;
	localparam int ROOT_W     = QUO_W / 2;
	localparam int SREM_W     = ROOT_W + 2;
	localparam int STEP_W     = 8;
	localparam logic [COS_W-1:0] ONE_Q30 = COS_W'(64'd1 << 30);

	typedef struct packed {
		logic signed [DOT_W-1:0] dot;
		logic [NORM_W-1:0]       norm_a;
		logic [NORM_W-1:0]       norm_b;
		logic [DIFF_W-1:0]       diff;
		logic                    too_long;
	} vec_sums_t;

	typedef struct packed {
		logic push;
		logic full;
	} sum_q_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} back_state_t;
endpackage
`default_nettype wire

[hdl/evd_if.sv]
// ---------------------------------------------------------------------------
// evd channel interfaces
// element pair channel and result channel, valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none
interface evd_pair_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [evd_pkg::ELEM_BITS-1:0] elem_a;
	logic signed [evd_pkg::ELEM_BITS-1:0] elem_b;
	logic                                 last_pair;
	modport source (output valid, elem_a, elem_b, last_pair, input ready);
	modport sink (input valid, elem_a, elem_b, last_pair, output ready);
endinterface

interface evd_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [evd_pkg::COS_W-1:0] cosine_sim;
	logic [evd_pkg::DIFF_W-1:0]       l2_square;
	logic [evd_pkg::ND_W-1:0]         norm_l2_square;
	logic                             zero_norm;
	logic                             too_long;
	modport source (output valid, cosine_sim, l2_square, norm_l2_square, zero_norm,
		too_long, input ready);
	modport sink (input valid, cosine_sim, l2_square, norm_l2_square, zero_norm,
		too_long, output ready);
endinterface
`default_nettype wire

[hdl/evd_front.sv]
// ---------------------------------------------------------------------------
// evd_front
// takes element pairs, forms products and keeps the saturating sums
// ---------------------------------------------------------------------------
`default_nettype none
module evd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	evd_pair_if.sink               pair_in,
	output evd_pkg::sum_q_ctl_t    ctl,
	input  wire logic              sum_full,
	output evd_pkg::vec_sums_t     sum_data
);
	localparam int PW = evd_pkg::PROD_X_W;

	logic                             stall, acc, keep;
	logic [evd_pkg::CNT_W-1:0]        cnt_q;
	logic                             ovf_q;
	logic                             valid_s1, last_s1, keep_s1, long_s1;
	logic signed [PW-1:0]             ab_s1, aa_s1, bb_s1, dd_s1;
	logic signed [evd_pkg::ELEM_BITS:0] a_x, b_x, d_x;
	logic signed [evd_pkg::DOT_W-1:0] dot_q;
	logic [evd_pkg::NORM_W-1:0]       na_q, nb_q;
	logic [evd_pkg::DIFF_W-1:0]       df_q;
	logic signed [evd_pkg::DOT_W:0]   dot_sum;
	logic [evd_pkg::NORM_W:0]         na_sum, nb_sum;
	logic [evd_pkg::DIFF_W:0]         df_sum;
	evd_pkg::vec_sums_t               nxt;

	assign stall = valid_s1 && last_s1 && sum_full;
	assign pair_in.ready = !stall;
	assign acc = pair_in.valid && !stall;
	assign keep = cnt_q < evd_pkg::CNT_W'(evd_pkg::MAX_LENGTH);

	assign a_x = (evd_pkg::ELEM_BITS+1)'(pair_in.elem_a);
	assign b_x = (evd_pkg::ELEM_BITS+1)'(pair_in.elem_b);
	assign d_x = a_x - b_x;

	// count pairs and flag the overlong vector at the door
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= acc;
			if (acc) begin
				if (pair_in.last_pair) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else if (keep) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ab_s1 <= PW'(a_x) * PW'(b_x);
			aa_s1 <= PW'(a_x) * PW'(a_x);
			bb_s1 <= PW'(b_x) * PW'(b_x);
			dd_s1 <= PW'(d_x) * PW'(d_x);
			last_s1 <= pair_in.last_pair;
			keep_s1 <= keep;
			long_s1 <= ovf_q || !keep;
		end
	end

	// saturating sums, one extra bit catches the overflow
	always_comb begin
		dot_sum = (evd_pkg::DOT_W+1)'(dot_q) + (evd_pkg::DOT_W+1)'(ab_s1);
		na_sum = (evd_pkg::NORM_W+1)'(na_q) + (evd_pkg::NORM_W+1)'($unsigned(aa_s1));
		nb_sum = (evd_pkg::NORM_W+1)'(nb_q) + (evd_pkg::NORM_W+1)'($unsigned(bb_s1));
		df_sum = (evd_pkg::DIFF_W+1)'(df_q) + (evd_pkg::DIFF_W+1)'($unsigned(dd_s1));
		nxt.dot = dot_q;
		nxt.norm_a = na_q;
		nxt.norm_b = nb_q;
		nxt.diff = df_q;
		nxt.too_long = long_s1;
		if (keep_s1) begin
			if (dot_sum[evd_pkg::DOT_W] != dot_sum[evd_pkg::DOT_W-1])
				nxt.dot = {dot_sum[evd_pkg::DOT_W], {(evd_pkg::DOT_W-1){!dot_sum[evd_pkg::DOT_W]}}};
			else
				nxt.dot = dot_sum[evd_pkg::DOT_W-1:0];
			nxt.norm_a = na_sum[evd_pkg::NORM_W] ? '1 : na_sum[evd_pkg::NORM_W-1:0];
			nxt.norm_b = nb_sum[evd_pkg::NORM_W] ? '1 : nb_sum[evd_pkg::NORM_W-1:0];
			nxt.diff = df_sum[evd_pkg::DIFF_W] ? '1 : df_sum[evd_pkg::DIFF_W-1:0];
		end
	end

	assign ctl.push = valid_s1 && last_s1 && !sum_full;
	assign ctl.full = sum_full;
	assign sum_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q <= '0;
			nb_q <= '0;
			df_q <= '0;
		end else if (valid_s1 && !stall) begin
			if (last_s1) begin
				dot_q <= '0;
				na_q <= '0;
				nb_q <= '0;
				df_q <= '0;
			end else begin
				dot_q <= nxt.dot;
				na_q <= nxt.norm_a;
				nb_q <= nxt.norm_b;
				df_q <= nxt.diff;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/evd_queue.sv]
// ---------------------------------------------------------------------------
// evd_queue
// two-entry queue of finished vector sums between front and back
// ---------------------------------------------------------------------------
`default_nettype none
module evd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  evd_pkg::sum_q_ctl_t  ctl,
	input  evd_pkg::vec_sums_t   wr_data,
	output logic                 full,
	output logic                 rd_valid,
	input  wire logic            pop,
	output evd_pkg::vec_sums_t   rd_data
);
	evd_pkg::vec_sums_t mem_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;

	assign full = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ctl.push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (ctl.push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({ctl.push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/evd_back.sv]
// ---------------------------------------------------------------------------
// evd_back
// serial cosine unit: norm product, long division, square root, result
// ---------------------------------------------------------------------------
`default_nettype none
`include "embedding_vector_distance_top_assert.svh"
module evd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           sum_valid,
	input  evd_pkg::vec_sums_t  sum_data,
	output logic                sum_pop,
	evd_result_if.source        result_out
);
	localparam int PP = evd_pkg::PP_W;
	localparam int MS = evd_pkg::MSQ_W;
	localparam int QW = evd_pkg::QUO_W;
	localparam int RW = evd_pkg::ROOT_W;
	localparam int SW = evd_pkg::SREM_W;
	localparam int TW = evd_pkg::STEP_W;

	evd_pkg::back_state_t state_q, state_d;
	logic [TW-1:0]                  step_q;
	logic [evd_pkg::NORM_W-1:0]     na_q;
	logic [PP-1:0]                  nb_sh_q, prod_q;
	logic [evd_pkg::MAG_W-1:0]      mag_sh_q, mag;
	logic [MS-1:0]                  mag_add_q, msq_q;
	logic [PP-1:0]                  rem_q;
	logic [PP:0]                    rem2;
	logic                           dge;
	logic [QW-1:0]                  quo_q;
	logic                           sat_q;
	logic [SW-1:0]                  srem_q, srem2, trial;
	logic                           sge;
	logic [RW-1:0]                  root_q, root_d;
	logic [1:0]                     pair;
	logic [RW:0]                    qv;
	logic [evd_pkg::COS_W-1:0]      qmag;
	logic signed [evd_pkg::COS_W-1:0] cos_q, cos_d;
	logic [evd_pkg::ND_W-1:0]       nd_q;
	logic [evd_pkg::DIFF_W-1:0]     diff_q;
	logic                           neg_q, zn_q, long_q, zn_in, last_step;

	assign zn_in = (sum_data.norm_a == '0) || (sum_data.norm_b == '0);
	assign mag = sum_data.dot[evd_pkg::DOT_W-1] ? $unsigned(-sum_data.dot)
		: $unsigned(sum_data.dot);

	always_comb begin
		unique case (state_q)
			evd_pkg::ST_MUL:  last_step = step_q == TW'(evd_pkg::MAG_W - 1);
			evd_pkg::ST_DIV:  last_step = step_q == TW'(evd_pkg::DVD_W - 1);
			evd_pkg::ST_SQRT: last_step = step_q == TW'(RW - 1);
			default:          last_step = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			evd_pkg::ST_IDLE: if (sum_valid) state_d = zn_in ? evd_pkg::ST_DONE
				: evd_pkg::ST_MUL;
			evd_pkg::ST_MUL:  if (last_step) state_d = evd_pkg::ST_DIV;
			evd_pkg::ST_DIV:  if (last_step) state_d = evd_pkg::ST_SQRT;
			evd_pkg::ST_SQRT: if (last_step) state_d = evd_pkg::ST_DONE;
			evd_pkg::ST_DONE: if (result_out.ready) state_d = evd_pkg::ST_IDLE;
			default:          state_d = evd_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		sum_pop = 1'b0;
		result_out.valid = 1'b0;
		unique case (state_q)
			evd_pkg::ST_IDLE: sum_pop = sum_valid;
			evd_pkg::ST_DONE: result_out.valid = 1'b1;
			default: ;
		endcase
	end

	assign result_out.cosine_sim = cos_q;
	assign result_out.l2_square = diff_q;
	assign result_out.norm_l2_square = nd_q;
	assign result_out.zero_norm = zn_q;
	assign result_out.too_long = long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= evd_pkg::ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= (state_d != state_q) ? '0 : step_q + 1'b1;
		end
	end

	// division step: dividend is msq followed by zero bits
	assign rem2 = {rem_q, msq_q[MS-1]};
	assign dge = rem2 >= {1'b0, prod_q};

	// square root step over the 64-bit quotient, clamped when it overflowed
	assign pair = sat_q ? 2'b11 : quo_q[QW-1:QW-2];
	assign srem2 = {srem_q[SW-3:0], pair};
	assign trial = {root_q, 2'b01};
	assign sge = srem2 >= trial;
	assign root_d = {root_q[RW-2:0], sge};

	always_comb begin
		qv = ((RW+1)'(root_d) + 1'b1) >> 1;
		qmag = (qv >= (RW+1)'(evd_pkg::ONE_Q30)) ? evd_pkg::ONE_Q30
			: evd_pkg::COS_W'(qv);
		cos_d = neg_q ? -$signed(qmag) : $signed(qmag);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			evd_pkg::ST_IDLE: begin
				na_q <= sum_data.norm_a;
				nb_sh_q <= PP'(sum_data.norm_b);
				prod_q <= '0;
				mag_sh_q <= mag;
				mag_add_q <= MS'(mag);
				msq_q <= '0;
				rem_q <= '0;
				quo_q <= '0;
				sat_q <= 1'b0;
				srem_q <= '0;
				root_q <= '0;
				neg_q <= sum_data.dot[evd_pkg::DOT_W-1];
				zn_q <= zn_in;
				long_q <= sum_data.too_long;
				diff_q <= sum_data.diff;
				cos_q <= '0;
				nd_q <= '0;
			end
			evd_pkg::ST_MUL: begin
				if (na_q[0])
					prod_q <= prod_q + nb_sh_q;
				na_q <= na_q >> 1;
				nb_sh_q <= nb_sh_q << 1;
				if (mag_sh_q[0])
					msq_q <= msq_q + mag_add_q;
				mag_sh_q <= mag_sh_q >> 1;
				mag_add_q <= mag_add_q << 1;
			end
			evd_pkg::ST_DIV: begin
				rem_q <= dge ? PP'(rem2 - {1'b0, prod_q}) : rem2[PP-1:0];
				msq_q <= msq_q << 1;
				sat_q <= sat_q | quo_q[QW-1];
				quo_q <= {quo_q[QW-2:0], dge};
			end
			evd_pkg::ST_SQRT: begin
				srem_q <= sge ? srem2 - trial : srem2;
				root_q <= root_d;
				quo_q <= quo_q << 2;
				if (last_step) begin
					cos_q <= cos_d;
					nd_q <= evd_pkg::ND_W'((evd_pkg::ND_W+1)'(64'd1 << 31)
						- ((evd_pkg::ND_W+1)'(cos_d) <<< 1));
				end
			end
			default: ;
		endcase
	end

	`EVD_ASSERT(a_cos_range, result_out.valid |-> (cos_q <= $signed(evd_pkg::ONE_Q30)) && (cos_q >= -$signed(evd_pkg::ONE_Q30)), "cosine out of range")
	`EVD_ASSERT(a_zero_norm, result_out.valid && zn_q |-> (cos_q == '0) && (nd_q == '0), "zero norm result not cleared")
	`EVD_ASSERT(a_pop_start, sum_pop |=> (state_q == evd_pkg::ST_MUL) || (state_q == evd_pkg::ST_DONE), "pop did not start work")
	`EVD_ASSERT_NEVER(a_pop_busy, sum_pop && (state_q != evd_pkg::ST_IDLE), "pop while busy")
endmodule
`default_nettype wire

[hdl/embedding_vector_distance_top.sv]
// ---------------------------------------------------------------------------
// embedding_vector_distance_top
// cosine similarity and squared euclidean distance of two streamed vectors
// ---------------------------------------------------------------------------
// element pairs enter one beat per cycle on pair_in, the last pair of a vector
// marked by last_pair; one result beat follows each vector on result_out.
// the front keeps the dot product, both squared norms and the squared
// difference sum, and hands them over a two-entry queue to a serial cosine
// unit: a shift-add product of the norms, a long division and a square root,
// run in turn after the sums are taken from the queue and skipped when a
// norm is zero; the result then waits on result_out until it is taken. the
// next vector streams in meanwhile; the front stalls only on a last pair
// when two finished vectors already wait in the queue.
`default_nettype none
module embedding_vector_distance_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	evd_pair_if.sink      pair_in,
	evd_result_if.source  result_out
);
	// handoff between accumulation and the cosine unit
	evd_pkg::sum_q_ctl_t ctl;
	evd_pkg::vec_sums_t  wr_data, rd_data;
	logic                full, rd_valid, pop;

	// accumulation of the element pairs
	evd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair_in  (pair_in),
		.ctl      (ctl),
		.sum_full (full),
		.sum_data (wr_data)
	);

	// finished vector sums wait here
	evd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.wr_data  (wr_data),
		.full     (full),
		.rd_valid (rd_valid),
		.pop      (pop),
		.rd_data  (rd_data)
	);

	// cosine, normalized distance and the result register
	evd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sum_valid  (rd_valid),
		.sum_data   (rd_data),
		.sum_pop    (pop),
		.result_out (result_out)
	);
endmodule
`default_nettype wire
